[rtl/core/nprms_pkg.sv]
// Package for the nearest-point RMS error unit.
// Holds sizes, action codes, controller states and command/status structs.
// Depends on nothing.
package nprms_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int FIELD_W    = 24;
    localparam int DIFF_W     = FIELD_W + 1;
    localparam int SQ_W       = 2 * FIELD_W + 1;
    localparam int DIST_W     = SQ_W + 1;
    localparam int SUM_W      = 64;
    localparam int BCOUNT_W   = 24;
    localparam int TCOUNT_W   = 32;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int RMS_W      = 25;
    localparam int ENTRY_W    = 3 * FIELD_W;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 80;
    localparam int STEP_W     = 6;
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLOSE = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_ERR,
        S_ACC,
        S_DIV,
        S_ROOT_INIT,
        S_SQRT,
        S_STORE,
        S_TOT_LOAD,
        S_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_tot;
        logic query_start;
        logic scan_step;
        logic err_calc;
        logic acc;
        logic div_start;
        logic div_step;
        logic sel_total;
        logic sqrt_start;
        logic sqrt_step;
        logic store_block;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic pipe_busy;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/core/nearest_point_rms_error_unit.sv]
// Load and clear totals take effect on accept. A query holds the input while
// the scan reads the store, one stored point per cycle, then adds its error.
// Close: 64 divider steps and 32 root steps for the block, then for the total;
// the result is loaded once a stalled result leaves the output register.
// One transaction in flight at a time; a result waits in the output register.
// Reset (rst_n, async, active low) empties the store and clears all sums.
module nearest_point_rms_error_unit
    import nprms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // x_coord, y_coord, field_value
    input  logic [1:0]            s_tuser,  // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // block_rms, total_rms,
                                            // block_queries, overflow_flag
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    nprms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .action   (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    nprms_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

`ifndef SYNTHESIS
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.out_load))
        else $error("result appeared without a load");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result overwritten while stalled");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !sts.pipe_busy)
        else $error("scan pipeline busy while accepting");
`endif

endmodule

[rtl/core/nprms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module nprms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/nprms_ctrl.sv]
// Controller state machine for the nearest-point RMS error unit.
// Depends on nprms_pkg.
module nprms_ctrl
    import nprms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic [1:0] action,
    output logic    in_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic sel_reg, sel_next;
    logic accept;
    action_t act;

    assign act    = action_t'(action);
    assign accept = in_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && act == ACT_QUERY)
                begin
                    state_next = S_SCAN;
                end
                else if (accept && act == ACT_CLOSE)
                begin
                    state_next = S_DIV;
                    cnt_next   = '0;
                    sel_next   = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done && !sts.pipe_busy)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_IDLE;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ROOT_INIT;
                end
            end
            S_ROOT_INIT:
            begin
                state_next = S_SQRT;
                cnt_next   = '0;
            end
            S_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    cnt_next = '0;
                    if (sel_reg)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_STORE;
                    end
                end
            end
            S_STORE:
            begin
                state_next = S_TOT_LOAD;
                sel_next   = 1'b1;
            end
            S_TOT_LOAD:
            begin
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        cmd.sel_total = sel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.load        = accept && act == ACT_LOAD;
                cmd.clear_tot   = accept && act == ACT_CLEAR;
                cmd.query_start = accept && act == ACT_QUERY;
                cmd.div_start   = accept && act == ACT_CLOSE;
                cmd.sel_total   = 1'b0;
            end
            S_SCAN:      cmd.scan_step = 1'b1;
            S_ERR:       cmd.err_calc  = 1'b1;
            S_ACC:       cmd.acc       = 1'b1;
            S_DIV:       cmd.div_step  = 1'b1;
            S_ROOT_INIT: cmd.sqrt_start = 1'b1;
            S_SQRT:      cmd.sqrt_step = 1'b1;
            S_STORE:     cmd.store_block = 1'b1;
            S_TOT_LOAD:  cmd.div_start = 1'b1;
            S_FIN:       cmd.out_load = sts.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

[rtl/core/nprms_dp.sv]
// Datapath: reference store, nearest-point scan pipeline, accumulators,
// shared divider and square-root units, output register.
// Depends on nprms_pkg and nprms_ram.
module nprms_dp
    import nprms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  dp_cmd_t               cmd,
    output dp_sts_t               sts,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    logic signed [FIELD_W-1:0] in_x, in_y, in_v;
    assign in_x = in_data[FIELD_W-1:0];
    assign in_y = in_data[2*FIELD_W-1:FIELD_W];
    assign in_v = in_data[3*FIELD_W-1:2*FIELD_W];

    logic [CNT_W-1:0] ref_count_reg, idx_reg;
    logic [ENTRY_W-1:0] rdata;
    logic store_full, issue;

    assign store_full = ref_count_reg == CNT_W'(MAX_POINTS);
    assign issue      = cmd.scan_step && (idx_reg != ref_count_reg);

    nprms_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_store (
        .clk   (clk),
        .we    (cmd.load && !store_full),
        .waddr (ref_count_reg[ADDR_W-1:0]),
        .wdata (in_data[ENTRY_W-1:0]),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (rdata)
    );

    logic signed [FIELD_W-1:0] qx_reg, qy_reg, qv_reg;
    logic p1_valid_reg, p1_first_reg, p2_valid_reg, p2_first_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg;
    logic signed [FIELD_W-1:0] p2_val_reg, nearest_reg;
    logic [DIST_W-1:0] best_reg, pt_dist;
    logic signed [DIFF_W-1:0] dx, dy, de;
    logic signed [2*DIFF_W-1:0] px, py, pe;
    logic signed [FIELD_W-1:0] rx, ry, rv;
    logic [SQ_W-1:0] e_reg;

    assign rx = rdata[FIELD_W-1:0];
    assign ry = rdata[2*FIELD_W-1:FIELD_W];
    assign rv = rdata[3*FIELD_W-1:2*FIELD_W];
    assign dx = DIFF_W'(rx) - DIFF_W'(qx_reg);
    assign dy = DIFF_W'(ry) - DIFF_W'(qy_reg);
    assign de = DIFF_W'(qv_reg) - DIFF_W'(nearest_reg);
    assign px = dx * dx;
    assign py = dy * dy;
    assign pe = de * de;
    assign pt_dist = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);

    logic [SUM_W-1:0] block_sum_reg, total_sum_reg;
    logic [BCOUNT_W-1:0] block_count_reg;
    logic [TCOUNT_W-1:0] total_count_reg;
    logic sticky_reg;
    logic [SUM_W:0] bsum_add, tsum_add;

    assign bsum_add = {1'b0, block_sum_reg} + (SUM_W+1)'(e_reg);
    assign tsum_add = {1'b0, total_sum_reg} + (SUM_W+1)'(e_reg);

    logic [SUM_W-1:0] quo_reg, sq_n_reg;
    logic [TCOUNT_W-1:0] dvs_reg, rem_reg;
    logic [TCOUNT_W:0] div_t;
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W+1:0] srem_reg;
    logic [ROOT_W+3:0] sq_t, sq_trial;
    logic [RMS_W-1:0] rms_val, block_rms_reg;
    logic zero_count;

    assign div_t    = {rem_reg, quo_reg[SUM_W-1]};
    assign sq_t     = {srem_reg, sq_n_reg[SUM_W-1:SUM_W-2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign zero_count = cmd.sel_total ? (total_count_reg == '0)
                                      : (block_count_reg == '0);
    assign rms_val = zero_count ? '0 :
                     (root_reg > ROOT_W'({RMS_W{1'b1}})) ? {RMS_W{1'b1}} :
                     root_reg[RMS_W-1:0];

    logic out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign sts.scan_done = idx_reg == ref_count_reg;
    assign sts.pipe_busy = p1_valid_reg || p2_valid_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg   <= '0;
            idx_reg         <= '0;
            p1_valid_reg    <= 1'b0;
            p2_valid_reg    <= 1'b0;
            block_sum_reg   <= '0;
            total_sum_reg   <= '0;
            block_count_reg <= '0;
            total_count_reg <= '0;
            sticky_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            if (cmd.query_start)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.load)
            begin
                if (store_full)
                begin
                    sticky_reg <= 1'b1;
                end
                else
                begin
                    ref_count_reg <= ref_count_reg + 1'b1;
                end
            end
            if (cmd.clear_tot)
            begin
                total_sum_reg   <= '0;
                total_count_reg <= '0;
                sticky_reg      <= 1'b0;
            end
            if (cmd.acc)
            begin
                block_sum_reg <= bsum_add[SUM_W] ? '1 : bsum_add[SUM_W-1:0];
                total_sum_reg <= tsum_add[SUM_W] ? '1 : tsum_add[SUM_W-1:0];
                if (block_count_reg != '1)
                begin
                    block_count_reg <= block_count_reg + 1'b1;
                end
                if (total_count_reg != '1)
                begin
                    total_count_reg <= total_count_reg + 1'b1;
                end
                if (bsum_add[SUM_W] || tsum_add[SUM_W] ||
                    block_count_reg == '1 || total_count_reg == '1)
                begin
                    sticky_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg   <= 1'b1;
                ref_count_reg   <= '0;
                block_sum_reg   <= '0;
                block_count_reg <= '0;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            qx_reg      <= in_x;
            qy_reg      <= in_y;
            qv_reg      <= in_v;
            nearest_reg <= '0;
        end
        p1_first_reg <= idx_reg == '0;
        sqx_reg      <= px[SQ_W-1:0];
        sqy_reg      <= py[SQ_W-1:0];
        p2_val_reg   <= rv;
        p2_first_reg <= p1_first_reg;
        if (p2_valid_reg && (p2_first_reg || pt_dist < best_reg))
        begin
            best_reg    <= pt_dist;
            nearest_reg <= p2_val_reg;
        end
        if (cmd.err_calc)
        begin
            e_reg <= pe[SQ_W-1:0];
        end
        if (cmd.div_start)
        begin
            quo_reg <= cmd.sel_total ? total_sum_reg : block_sum_reg;
            dvs_reg <= cmd.sel_total ? total_count_reg
                                     : TCOUNT_W'(block_count_reg);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_t >= {1'b0, dvs_reg})
            begin
                rem_reg <= TCOUNT_W'(div_t - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= div_t[TCOUNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.sqrt_start)
        begin
            sq_n_reg <= quo_reg;
            root_reg <= '0;
            srem_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_n_reg <= {sq_n_reg[SUM_W-3:0], 2'b00};
            if (sq_t >= sq_trial)
            begin
                srem_reg <= (ROOT_W+2)'(sq_t - sq_trial);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= sq_t[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.store_block)
        begin
            block_rms_reg <= rms_val;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {5'b0, sticky_reg, block_count_reg, rms_val,
                             block_rms_reg};
        end
    end

endmodule
